>>> hw/rtl/skvt_pkg.sv
package skvt_pkg;

    // Fixed widths of the position, status and command fields
    localparam int POS_BITS    = 9;
    localparam int STATUS_BITS = 3;
    localparam int CMD_BITS    = 2;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_FIND   = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_CLEAR  = 2'd3
    } command_t;

    typedef enum logic [STATUS_BITS-1:0] {
        STAT_OK        = 3'd0,
        STAT_NOT_FOUND = 3'd1,
        STAT_FULL      = 3'd2,
        STAT_BAD_POS   = 3'd3,
        STAT_UNSORTED  = 3'd4
    } status_t;

    // Action applied by every cell of the chain in the update cycle
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_WRITE,
        CELL_INSERT,
        CELL_REMOVE
    } cell_op_t;

    typedef enum logic {
        ST_IDLE,
        ST_APPLY
    } state_t;

endpackage

>>> hw/rtl/skvt_cell.sv
module skvt_cell #(
    parameter int IDX        = 0,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 64,
    parameter int PW         = 9,
    parameter int CW         = 9
) (
    input  logic                     clk,
    input  logic                     sample,
    input  logic [KEY_BITS-1:0]      probe_key,
    input  logic [skvt_pkg::POS_BITS-1:0] probe_pos,
    input  logic [PW-1:0]            count,
    input  skvt_pkg::cell_op_t       op,
    input  logic [KEY_BITS-1:0]      new_key,
    input  logic [VALUE_BITS-1:0]    new_value,
    input  logic [KEY_BITS-1:0]      lo_key,
    input  logic [VALUE_BITS-1:0]    lo_value,
    input  logic                     lo_le,
    input  logic                     lo_lt,
    input  logic [KEY_BITS-1:0]      hi_key,
    input  logic [VALUE_BITS-1:0]    hi_value,
    output logic [KEY_BITS-1:0]      key_q,
    output logic [VALUE_BITS-1:0]    value_q,
    output logic                     le_q,
    output logic                     lt_q,
    output logic                     eq_q,
    output logic                     bnd_lt,
    output logic                     bnd_le
);
    import skvt_pkg::*;

    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] value_reg;
    logic                  le_reg;
    logic                  lt_reg;
    logic                  eq_reg;
    logic                  rm_reg;
    logic                  live;

    // This cell holds a live entry while its position is within the count
    assign live = (PW'(IDX) < count);

    // Latch the compare flags against the incoming word
    always_ff @(posedge clk)
    begin
        if (sample)
        begin
            le_reg <= live && (key_reg <= probe_key);
            lt_reg <= live && (key_reg < probe_key);
            eq_reg <= live && (key_reg == probe_key);
            rm_reg <= (CW'(IDX + 1) >= CW'(probe_pos));
        end
    end

    // Boundary of the sorted run, seen from the lower neighbour
    assign bnd_lt = lo_lt && !lt_reg;
    assign bnd_le = lo_le && !le_reg;

    // Overwrite, take the new entry, or shift from a neighbour
    always_ff @(posedge clk)
    begin
        case (op)
            CELL_WRITE:
            begin
                if (bnd_lt && eq_reg)
                begin
                    value_reg <= new_value;
                end
            end
            CELL_INSERT:
            begin
                if (bnd_le)
                begin
                    key_reg   <= new_key;
                    value_reg <= new_value;
                end
                else if (!lo_le)
                begin
                    key_reg   <= lo_key;
                    value_reg <= lo_value;
                end
            end
            CELL_REMOVE:
            begin
                if (rm_reg)
                begin
                    key_reg   <= hi_key;
                    value_reg <= hi_value;
                end
            end
            default:
            begin
                key_reg   <= key_reg;
                value_reg <= value_reg;
            end
        endcase
    end

    assign key_q   = key_reg;
    assign value_q = value_reg;
    assign le_q    = le_reg;
    assign lt_q    = lt_reg;
    assign eq_q    = eq_reg;

endmodule

>>> hw/rtl/skvt_enc.sv
module skvt_enc #(
    parameter int N = 256,
    parameter int W = 8
) (
    input  logic [N-1:0] onehot,
    output logic [W-1:0] idx
);

    // Fold the index of the single set bit into a binary number
    always_comb
    begin
        idx = '0;
        for (int i = 0; i < N; i++)
        begin
            if (onehot[i])
            begin
                idx = idx | W'(i);
            end
        end
    end

endmodule

>>> hw/rtl/sorted_key_value_table_top.sv
// Sorted key/value table built as a chain of CAPACITY cells, one entry per
// cell, kept in ascending unsigned key order at positions 1..entry_count.
// For each word, every cell compares its key with the incoming key at once
// in the accept cycle; in the update cycle the match boundary is encoded,
// the whole chain shifts, overwrites or holds in one step and the result
// word is loaded into the output register. in_ready is high whenever no
// word is being worked on; a result not yet taken holds the chain in its
// update cycle until out_ready frees the output register. Users write
// multi_mode via cfg_write/cfg_data only while the table is idle (unchecked).
module sorted_key_value_table_top #(
    parameter int CAPACITY   = 256,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic                              cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [skvt_pkg::CMD_BITS-1:0]     command,
    input  logic [KEY_BITS-1:0]               key,
    input  logic [VALUE_BITS-1:0]             value,
    input  logic [skvt_pkg::POS_BITS-1:0]     position,
    input  logic                              batch_end,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [skvt_pkg::POS_BITS-1:0]     result_position,
    output logic [skvt_pkg::STATUS_BITS-1:0]  status,
    output logic [skvt_pkg::POS_BITS-1:0]     entry_count
);
    import skvt_pkg::*;

    localparam int PW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam int CW = (PW > POS_BITS) ? PW : POS_BITS;

    state_t                 state_reg, state_next;
    command_t               cmd_reg;
    logic [KEY_BITS-1:0]    key_reg;
    logic [VALUE_BITS-1:0]  value_reg;
    logic [POS_BITS-1:0]    pos_reg;
    logic                   last_reg;
    logic                   ordered_reg;
    logic [PW-1:0]          count_reg, count_next;
    logic [KEY_BITS-1:0]    prev_key_reg, prev_key_next;
    logic                   in_batch_reg, in_batch_next;
    logic                   multi_mode_reg;
    logic                   out_valid_reg;
    logic [POS_BITS-1:0]    result_position_reg;
    status_t                status_reg;
    logic [POS_BITS-1:0]    entry_count_reg;

    logic                   accept;
    logic                   done;
    logic                   ordered;
    cell_op_t               cell_op;
    status_t                stat_calc;
    logic [PW-1:0]          result_calc;
    logic [CW-1:0]          result_wide;
    logic [CW-1:0]          count_wide;
    logic                   found;
    logic                   bad_pos;

    logic [KEY_BITS-1:0]    key_w   [CAPACITY];
    logic [VALUE_BITS-1:0]  value_w [CAPACITY];
    logic [CAPACITY-1:0]    le_w;
    logic [CAPACITY-1:0]    lt_w;
    logic [CAPACITY-1:0]    eq_w;
    logic [CAPACITY-1:0]    bnd_lt_w;
    logic [CAPACITY-1:0]    bnd_le_w;
    logic [IW-1:0]          n_lt;
    logic [IW-1:0]          n_le;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE);
    assign done     = !out_valid_reg || out_ready;

    // Check the batch order against the last in-order find or insert key
    always_comb
    begin
        ordered = 1'b1;
        if (in_batch_reg)
        begin
            ordered = multi_mode_reg ? (key >= prev_key_reg) : (key > prev_key_reg);
        end
    end

    // Chain of cells
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [KEY_BITS-1:0]   lo_key, hi_key;
        logic [VALUE_BITS-1:0] lo_value, hi_value;
        logic                  lo_le, lo_lt;

        if (i == 0)
        begin : g_first
            assign lo_key   = key_reg;
            assign lo_value = value_reg;
            assign lo_le    = 1'b1;
            assign lo_lt    = 1'b1;
        end
        else
        begin : g_mid
            assign lo_key   = key_w[i-1];
            assign lo_value = value_w[i-1];
            assign lo_le    = le_w[i-1];
            assign lo_lt    = lt_w[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign hi_key   = key_w[i];
            assign hi_value = value_w[i];
        end
        else
        begin : g_upper
            assign hi_key   = key_w[i+1];
            assign hi_value = value_w[i+1];
        end

        skvt_cell #(
            .IDX        (i),
            .KEY_BITS   (KEY_BITS),
            .VALUE_BITS (VALUE_BITS),
            .PW         (PW),
            .CW         (CW)
        ) u_cell (
            .clk       (clk),
            .sample    (accept),
            .probe_key (key),
            .probe_pos (position),
            .count     (count_reg),
            .op        (cell_op),
            .new_key   (key_reg),
            .new_value (value_reg),
            .lo_key    (lo_key),
            .lo_value  (lo_value),
            .lo_le     (lo_le),
            .lo_lt     (lo_lt),
            .hi_key    (hi_key),
            .hi_value  (hi_value),
            .key_q     (key_w[i]),
            .value_q   (value_w[i]),
            .le_q      (le_w[i]),
            .lt_q      (lt_w[i]),
            .eq_q      (eq_w[i]),
            .bnd_lt    (bnd_lt_w[i]),
            .bnd_le    (bnd_le_w[i])
        );
    end

    // Encode the first entry not below the key, and the first entry above it
    skvt_enc #(.N(CAPACITY), .W(IW)) u_enc_lt (.onehot(bnd_lt_w), .idx(n_lt));
    skvt_enc #(.N(CAPACITY), .W(IW)) u_enc_le (.onehot(bnd_le_w), .idx(n_le));

    assign found   = |eq_w;
    assign bad_pos = (pos_reg == '0) || (CW'(pos_reg) > CW'(count_reg));

    // Decide the command outcome and the chain action
    always_comb
    begin
        state_next    = state_reg;
        cell_op       = CELL_HOLD;
        stat_calc     = STAT_OK;
        result_calc   = '0;
        count_next    = count_reg;
        prev_key_next = prev_key_reg;
        in_batch_next = in_batch_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                if (done)
                begin
                    state_next = ST_IDLE;
                    case (cmd_reg)
                        CMD_FIND, CMD_INSERT:
                        begin
                            if (!ordered_reg)
                            begin
                                stat_calc = STAT_UNSORTED;
                            end
                            else
                            begin
                                prev_key_next = key_reg;
                                if (cmd_reg == CMD_FIND)
                                begin
                                    if (found)
                                    begin
                                        result_calc = PW'(n_lt) + PW'(1);
                                    end
                                    else
                                    begin
                                        stat_calc = STAT_NOT_FOUND;
                                    end
                                end
                                else if (!multi_mode_reg && found)
                                begin
                                    cell_op     = CELL_WRITE;
                                    result_calc = PW'(n_lt) + PW'(1);
                                end
                                else if (count_reg == PW'(CAPACITY))
                                begin
                                    stat_calc = STAT_FULL;
                                end
                                else
                                begin
                                    cell_op     = CELL_INSERT;
                                    count_next  = count_reg + PW'(1);
                                    result_calc = PW'(n_le) + PW'(1);
                                end
                            end
                            in_batch_next = !last_reg;
                        end
                        CMD_REMOVE:
                        begin
                            if (bad_pos)
                            begin
                                stat_calc = STAT_BAD_POS;
                            end
                            else
                            begin
                                cell_op    = CELL_REMOVE;
                                count_next = count_reg - PW'(1);
                            end
                            in_batch_next = 1'b0;
                        end
                        default:
                        begin
                            count_next    = '0;
                            in_batch_next = 1'b0;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign result_wide = CW'(result_calc);
    assign count_wide  = CW'(count_next);

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            prev_key_reg   <= '0;
            in_batch_reg   <= 1'b0;
            multi_mode_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            prev_key_reg <= prev_key_next;
            in_batch_reg <= in_batch_next;
            if (cfg_write)
            begin
                multi_mode_reg <= cfg_data;
            end
            if (state_reg == ST_APPLY && done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the accepted word and load the result word
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg     <= command_t'(command);
            key_reg     <= key;
            value_reg   <= value;
            pos_reg     <= position;
            last_reg    <= batch_end;
            ordered_reg <= ordered;
        end
        if (state_reg == ST_APPLY && done)
        begin
            result_position_reg <= result_wide[POS_BITS-1:0];
            status_reg          <= stat_calc;
            entry_count_reg     <= count_wide[POS_BITS-1:0];
        end
    end

    assign out_valid       = out_valid_reg;
    assign result_position = result_position_reg;
    assign status          = status_reg;
    assign entry_count     = entry_count_reg;

endmodule

>>> hw/rtl/skvt_checker.sv
module skvt_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic [skvt_pkg::POS_BITS-1:0]     result_position,
    input logic [skvt_pkg::STATUS_BITS-1:0]  status,
    input logic [skvt_pkg::POS_BITS-1:0]     entry_count
);
    import skvt_pkg::*;

    // One word at a time: no accept in the update cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken during update cycle");

    // Status stays within its codes
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status <= STAT_UNSORTED))
        else $error("status code out of range");

    // Failed commands report no position
    a_fail_no_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != STAT_OK) |-> (result_position == '0))
        else $error("position reported on failed command");

    // A stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
        (out_valid && $stable(result_position) && $stable(status) && $stable(entry_count)))
        else $error("result word changed while stalled");

endmodule

bind sorted_key_value_table_top skvt_checker u_skvt_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .result_position (result_position),
    .status          (status),
    .entry_count     (entry_count)
);

>>> tb/sorted_key_value_table_top_tb.sv
`timescale 1ns / 1ps

module sorted_key_value_table_top_tb;

    import skvt_pkg::*;

    localparam int DEPTH       = 256;
    localparam int KEY_W       = 32;
    localparam int VAL_W       = 64;
    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE      = 6;

    typedef struct {
        command_t          cmd;
        logic [KEY_W-1:0]  k;
        logic [VAL_W-1:0]  v;
        logic [POS_BITS-1:0] pos;
        logic              last;
    } table_word_t;

    typedef struct {
        logic [POS_BITS-1:0] position;
        status_t             stat;
        logic [POS_BITS-1:0] count;
    } table_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic cfg_data = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    command_t command = CMD_FIND;
    logic [KEY_W-1:0] key = '0;
    logic [VAL_W-1:0] value = '0;
    logic [POS_BITS-1:0] position = '0;
    logic batch_end = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [POS_BITS-1:0] result_position;
    logic [STATUS_BITS-1:0] status;
    logic [POS_BITS-1:0] entry_count;

    // Shadow copy of the table and its batch tracking
    logic [KEY_W-1:0] tbl_key [1:DEPTH];
    logic [VAL_W-1:0] tbl_val [1:DEPTH];
    int unsigned      tbl_count = 0;
    logic [KEY_W-1:0] last_key = '0;
    bit               batch_open = 1'b0;
    bit               dup_mode = 1'b0;

    table_word_t   pending_words [$];
    table_result_t table_replies [$];
    int            words_queued = 0;
    int            faults = 0;
    int            cycle_count = 0;
    int            gap_left = 0;
    int            burst_left = 0;
    logic [7:0]    stall_tick = '0;

    sorted_key_value_table_top #(
        .CAPACITY  (DEPTH),
        .KEY_BITS  (KEY_W),
        .VALUE_BITS(VAL_W)
    ) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .command        (command),
        .key            (key),
        .value          (value),
        .position       (position),
        .batch_end      (batch_end),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .result_position(result_position),
        .status         (status),
        .entry_count    (entry_count)
    );

    always #6 clk = ~clk;

    // Lowest live position holding k, 0 when absent
    function automatic int unsigned lowest_match(logic [KEY_W-1:0] k);
        int unsigned p;
        for (p = 1; p <= tbl_count; p++)
        begin
            if (tbl_key[p] == k)
                return p;
        end
        return 0;
    endfunction

    // Apply one word to the shadow table and return the reply it gives
    function automatic table_result_t table_apply(table_word_t w);
        table_result_t r;
        bit            ordered;
        int unsigned   hit;
        int unsigned   at;
        int unsigned   p;
        r.position = '0;
        r.stat     = STAT_OK;
        if (w.cmd == CMD_FIND || w.cmd == CMD_INSERT)
        begin
            ordered = 1'b1;
            if (batch_open)
                ordered = dup_mode ? (w.k >= last_key) : (w.k > last_key);
            if (!ordered)
            begin
                r.stat = STAT_UNSORTED;
            end
            else
            begin
                last_key = w.k;
                if (w.cmd == CMD_FIND)
                begin
                    hit = lowest_match(w.k);
                    r.position = POS_BITS'(hit);
                    if (hit == 0)
                        r.stat = STAT_NOT_FOUND;
                end
                else
                begin
                    hit = dup_mode ? 0 : lowest_match(w.k);
                    if (hit != 0)
                    begin
                        tbl_val[hit] = w.v;
                        r.position = POS_BITS'(hit);
                    end
                    else if (tbl_count >= DEPTH)
                    begin
                        r.stat = STAT_FULL;
                    end
                    else
                    begin
                        // new key goes after every key not above it
                        at = 1;
                        for (p = 1; p <= tbl_count; p++)
                        begin
                            if (tbl_key[p] <= w.k)
                                at++;
                        end
                        for (p = tbl_count + 1; p > at; p--)
                        begin
                            tbl_key[p] = tbl_key[p-1];
                            tbl_val[p] = tbl_val[p-1];
                        end
                        tbl_key[at] = w.k;
                        tbl_val[at] = w.v;
                        tbl_count++;
                        r.position = POS_BITS'(at);
                    end
                end
            end
            batch_open = !w.last;
        end
        else if (w.cmd == CMD_REMOVE)
        begin
            if (w.pos == 0 || w.pos > tbl_count)
            begin
                r.stat = STAT_BAD_POS;
            end
            else
            begin
                for (p = w.pos; p < tbl_count; p++)
                begin
                    tbl_key[p] = tbl_key[p+1];
                    tbl_val[p] = tbl_val[p+1];
                end
                tbl_count--;
            end
            batch_open = 1'b0;
        end
        else
        begin
            tbl_count  = 0;
            batch_open = 1'b0;
        end
        r.count = POS_BITS'(tbl_count);
        return r;
    endfunction

    task automatic queue_word(command_t c, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v,
                              logic [POS_BITS-1:0] p, logic e);
        table_word_t w;
        w.cmd  = c;
        w.k    = k;
        w.v    = v;
        w.pos  = p;
        w.last = e;
        pending_words.push_back(w);
        words_queued++;
    endtask

    // One ascending batch of finds and inserts, now and then broken
    task automatic queue_batch(bit narrow);
        int unsigned      len;
        int unsigned      i;
        logic [KEY_W-1:0] k;
        logic [KEY_W-1:0] sent;
        command_t         c;
        logic             e;
        len = $urandom_range(1, 8);
        k = narrow ? KEY_W'($urandom_range(0, 15)) : KEY_W'($urandom);
        for (i = 0; i < len; i++)
        begin
            c = ($urandom_range(0, 9) < 5) ? CMD_INSERT : CMD_FIND;
            e = (i == len - 1) && ($urandom_range(0, 19) != 0);
            if (i > 0 && $urandom_range(0, 19) == 0)
            begin
                // out of order: a step backwards, or an equal key (in order in multi mode)
                sent = $urandom_range(0, 1) ? k : k - KEY_W'($urandom_range(1, 3));
            end
            else
            begin
                if (i > 0)
                begin
                    if (narrow)
                        k = k + KEY_W'(dup_mode ? $urandom_range(0, 2) : $urandom_range(1, 3));
                    else
                        k = k + KEY_W'($urandom_range(dup_mode ? 0 : 1, 1 << 20));
                end
                sent = k;
            end
            queue_word(c, sent, {$urandom, $urandom}, POS_BITS'($urandom_range(0, DEPTH)), e);
        end
    endtask

    task automatic queue_random(int n);
        int start;
        int pick;
        start = words_queued;
        while (words_queued - start < n)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 75)
                queue_batch($urandom_range(0, 2) != 0);
            else if (pick < 88)
                queue_word(CMD_REMOVE, KEY_W'($urandom), {$urandom, $urandom},
                           ($urandom_range(0, 7) == 0) ? POS_BITS'($urandom_range(0, DEPTH))
                                                       : POS_BITS'($urandom_range(1, 24)),
                           1'($urandom));
            else if (pick < 92)
                queue_word(CMD_CLEAR, KEY_W'($urandom), {$urandom, $urandom},
                           POS_BITS'($urandom_range(0, DEPTH)), 1'($urandom));
            else
                queue_word(command_t'($urandom_range(0, 3)), KEY_W'($urandom),
                           {$urandom, $urandom}, POS_BITS'($urandom_range(0, DEPTH)),
                           1'($urandom));
        end
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_words.size() != 0 || in_valid || table_replies.size() != 0);
    endtask

    task automatic set_duplicates(bit m);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= m;
        @(posedge clk);
        cfg_write <= 1'b0;
        dup_mode = m;
        @(negedge clk);
    endtask

    // Sender: offer queued words in bursts, predict each word as it is taken
    always @(posedge clk)
    begin : drive
        table_word_t taken;
        table_word_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                taken.cmd  = command;
                taken.k    = key;
                taken.v    = value;
                taken.pos  = position;
                taken.last = batch_end;
                table_replies.push_back(table_apply(taken));
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_words.size() != 0)
                begin
                    nxt = pending_words.pop_front();
                    in_valid  <= 1'b1;
                    command   <= nxt.cmd;
                    key       <= nxt.k;
                    value     <= nxt.v;
                    position  <= nxt.pos;
                    batch_end <= nxt.last;
                    if (burst_left > 0)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = $urandom_range(0, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each reply word against the oldest prediction
    always @(posedge clk)
    begin : observe
        table_result_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (table_replies.size() == 0)
                begin
                    $error("reply word with none predicted: position %0d status %0d count %0d",
                           result_position, status, entry_count);
                    faults++;
                end
                else
                begin
                    want = table_replies.pop_front();
                    if (result_position !== want.position)
                    begin
                        $error("result_position: expected %0d, actual %0d",
                               want.position, result_position);
                        faults++;
                    end
                    if (status !== want.stat)
                    begin
                        $error("status: expected %0d, actual %0d", want.stat, status);
                        faults++;
                    end
                    if (entry_count !== want.count)
                    begin
                        $error("entry_count: expected %0d, actual %0d", want.count, entry_count);
                        faults++;
                    end
                end
            end
            // stall pattern: open, coin toss, light, long stalls
            stall_tick <= stall_tick + 8'd1;
            case (stall_tick[7:6])
                2'd0: out_ready <= 1'b1;
                2'd1: out_ready <= 1'($urandom_range(0, 1));
                2'd2: out_ready <= ($urandom_range(0, 7) != 0);
                default: out_ready <= (stall_tick[2:0] == 3'd0);
            endcase
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        int i;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        set_duplicates(1'b0);

        // unique mode: extremes, overwrite, batch order, bad positions
        queue_word(CMD_FIND,   32'd0,         64'd0, 9'd0, 1'b1);
        queue_word(CMD_INSERT, 32'd0,         64'd0, 9'd0, 1'b1);
        queue_word(CMD_INSERT, 32'hFFFF_FFFF, {VAL_W{1'b1}}, 9'd0, 1'b1);
        queue_word(CMD_INSERT, 32'd100,       {$urandom, $urandom}, 9'd0, 1'b1);
        queue_word(CMD_FIND,   32'd0,         64'd0, 9'd0, 1'b0);
        queue_word(CMD_FIND,   32'd100,       64'd0, 9'd0, 1'b0);
        queue_word(CMD_FIND,   32'd100,       64'd0, 9'd0, 1'b0);
        queue_word(CMD_FIND,   32'd50,        64'd0, 9'd0, 1'b1);
        queue_word(CMD_INSERT, 32'd100,       {$urandom, $urandom}, 9'd0, 1'b1);
        queue_word(CMD_INSERT, 32'd200,       {$urandom, $urandom}, 9'd0, 1'b0);
        queue_word(CMD_INSERT, 32'd150,       {$urandom, $urandom}, 9'd0, 1'b0);
        queue_word(CMD_INSERT, 32'd300,       {$urandom, $urandom}, 9'd0, 1'b1);
        queue_word(CMD_FIND,   32'hFFFF_FFFF, 64'd0, 9'd0, 1'b1);
        queue_word(CMD_FIND,   32'd7,         64'd0, 9'd0, 1'b1);
        queue_word(CMD_REMOVE, 32'd0,         64'd0, 9'd0, 1'b1);
        queue_word(CMD_REMOVE, 32'd0,         64'd0, 9'd256, 1'b1);
        queue_word(CMD_REMOVE, 32'd0,         64'd0, 9'd6, 1'b1);
        queue_word(CMD_REMOVE, 32'd0,         64'd0, 9'd2, 1'b1);
        queue_word(CMD_INSERT, 32'd500,       {$urandom, $urandom}, 9'd0, 1'b0);
        queue_word(CMD_REMOVE, 32'd0,         64'd0, 9'd1, 1'b0);
        queue_word(CMD_INSERT, 32'd10,        {$urandom, $urandom}, 9'd0, 1'b1);
        queue_word(CMD_FIND,   32'd5,         64'd0, 9'd0, 1'b0);
        queue_word(CMD_CLEAR,  32'd0,         64'd0, 9'd0, 1'b0);
        queue_word(CMD_FIND,   32'd1,         64'd0, 9'd0, 1'b1);
        wait_idle();
        set_duplicates(1'b1);

        // multi mode: duplicates in a batch, lowest match on find
        queue_word(CMD_INSERT, 32'd7, {$urandom, $urandom}, 9'd0, 1'b0);
        queue_word(CMD_INSERT, 32'd7, {$urandom, $urandom}, 9'd0, 1'b0);
        queue_word(CMD_INSERT, 32'd7, {$urandom, $urandom}, 9'd0, 1'b0);
        queue_word(CMD_INSERT, 32'd6, {$urandom, $urandom}, 9'd0, 1'b1);
        queue_word(CMD_FIND,   32'd7, 64'd0, 9'd0, 1'b1);
        queue_word(CMD_REMOVE, 32'd0, 64'd0, 9'd2, 1'b1);
        queue_random(380);
        wait_idle();
        set_duplicates(1'b0);
        queue_random(400);
        wait_idle();

        // fill the table to capacity with duplicates, then overflow it
        set_duplicates(1'b1);
        queue_word(CMD_CLEAR,  32'd0, 64'd0, 9'd0, 1'b1);
        queue_word(CMD_INSERT, 32'd5, {$urandom, $urandom}, 9'd0, 1'b1);
        for (i = 1; i < DEPTH + 3; i++)
            queue_word(CMD_INSERT, KEY_W'($urandom_range(0, 63)), {$urandom, $urandom},
                       9'd0, 1'b1);
        queue_word(CMD_FIND, 32'd5, 64'd0, 9'd0, 1'b1);
        wait_idle();

        // unique mode on a full table: overwrite still works, new keys refused
        set_duplicates(1'b0);
        queue_word(CMD_INSERT, 32'd5,         {$urandom, $urandom}, 9'd0, 1'b1);
        queue_word(CMD_INSERT, 32'hDEAD_0000, {$urandom, $urandom}, 9'd0, 1'b1);
        queue_word(CMD_REMOVE, 32'd0,         64'd0, 9'd256, 1'b1);
        queue_word(CMD_REMOVE, 32'd0,         64'd0, 9'd0, 1'b1);
        queue_word(CMD_INSERT, 32'hDEAD_0000, {$urandom, $urandom}, 9'd0, 1'b1);
        queue_word(CMD_INSERT, 32'hDEAD_0001, {$urandom, $urandom}, 9'd0, 1'b1);
        queue_word(CMD_FIND,   32'hDEAD_0000, 64'd0, 9'd0, 1'b1);
        queue_random(300);
        wait_idle();
        set_duplicates(1'b1);
        queue_random(380);

        wait_idle();
        repeat (SETTLE) @(posedge clk);
        if (faults == 0 && table_replies.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/skvt_pkg.sv
hw/rtl/skvt_cell.sv
hw/rtl/skvt_enc.sv
hw/rtl/sorted_key_value_table_top.sv
hw/rtl/skvt_checker.sv
tb/sorted_key_value_table_top_tb.sv
